@@ hdl/request_id_allocator_with_credits_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the request ID allocator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef REQUEST_ID_ALLOCATOR_WITH_CREDITS_DEFINES_SVH
`define REQUEST_ID_ALLOCATOR_WITH_CREDITS_DEFINES_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset
`define RTA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("request ID allocator check failed");

// Antecedent in this cycle implies consequent in the next
`define RTA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("request ID allocator check failed");

`else

`define RTA_ASSERT(name, clk, rst, prop)
`define RTA_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

@@ hdl/rta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_pkg
// Shared constants, codes and the queued command type of the ID allocator.
// ----------------------------------------------------------------------------
package rta_pkg;

   // Table geometry
   localparam int ID_COUNT    = 256;
   localparam int ID_BITS     = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
   localparam int STATUS_BITS = 8;

   // Fixed port widths
   localparam int MODE_BITS     = 2;
   localparam int MSG_ID_BITS   = 8;
   localparam int CODE_BITS     = 8;
   localparam int ERR_BITS      = 2;
   localparam int CREDIT_BITS   = 8;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 8;

   // Front queue geometry (depth is a power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Credit limits
   localparam logic [CREDIT_BITS-1:0] SLOT_LIMIT_RESET = 8'd16;
   localparam logic [CREDIT_BITS-1:0] CREDIT_MAX       = 8'hFF;

   // Request modes
   localparam logic [MODE_BITS-1:0] OP_SEND     = 2'd0;
   localparam logic [MODE_BITS-1:0] OP_RX_REPLY = 2'd1;
   localparam logic [MODE_BITS-1:0] OP_RX_REQ   = 2'd2;
   localparam logic [MODE_BITS-1:0] OP_TX_REPLY = 2'd3;

   // Result error codes
   localparam logic [ERR_BITS-1:0] ERR_OK        = 2'd0;
   localparam logic [ERR_BITS-1:0] ERR_NO_CREDIT = 2'd1;
   localparam logic [ERR_BITS-1:0] ERR_UNKNOWN   = 2'd2;
   localparam logic [ERR_BITS-1:0] ERR_NO_ID     = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOT_LIMIT   = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PENDING_CODE = 1'd1;

   // Classified request as it waits between front and back
   typedef struct packed {
      logic [MODE_BITS-1:0]   op;
      logic [ID_BITS-1:0]     id;
      logic [MSG_ID_BITS-1:0] msg_id;
      logic [STATUS_BITS-1:0] code;
      logic                   id_ok;
   } cmd_type;

   // Advance an ID, wrapping at the top of the table
   function automatic logic [ID_BITS-1:0] wrap_next(input logic [ID_BITS-1:0] id);
      logic [ID_BITS-1:0] nxt;
      if (id == ID_BITS'(ID_COUNT - 1)) begin
         nxt = '0;
      end else begin
         nxt = id + 1'b1;
      end
      return nxt;
   endfunction

endpackage

@@ hdl/rta_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`include "request_id_allocator_with_credits_defines.svh"

module rta_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rta_pkg::MODE_BITS-1:0]      req_mode,
   input  logic [rta_pkg::MSG_ID_BITS-1:0]    req_message_id,
   input  logic [rta_pkg::CODE_BITS-1:0]      req_status_code,
   output logic                               q_valid,
   output rta_pkg::cmd_type                   q_data,
   input  logic                               q_pop
);

   rta_pkg::cmd_type                    entry_mem [rta_pkg::QUEUE_DEPTH];
   logic [rta_pkg::QPTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rta_pkg::QPTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rta_pkg::QCNT_BITS-1:0]       count_ff, count_in;
   logic                                push;
   rta_pkg::cmd_type                    cmd_new;

   // Classify the incoming request
   always_comb begin
      cmd_new.op     = req_mode;
      cmd_new.id     = rta_pkg::ID_BITS'(req_message_id);
      cmd_new.msg_id = req_message_id;
      cmd_new.code   = rta_pkg::STATUS_BITS'(req_status_code);
      cmd_new.id_ok  = (32'(req_message_id) < 32'(rta_pkg::ID_COUNT));
   end

   // Stall while the queue is full
   assign req_stall = (count_ff == rta_pkg::QCNT_BITS'(rta_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_data    = entry_mem[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified request
   always_ff @(posedge clock) begin
      if (push) begin
         entry_mem[wr_ptr_ff] <= cmd_new;
      end
   end

   `RTA_ASSERT(a_front_count_bound, clock, reset, count_ff <= rta_pkg::QCNT_BITS'(rta_pkg::QUEUE_DEPTH))
   `RTA_ASSERT_NEXT(a_front_pop_drains, clock, reset, q_pop && !push, count_ff == $past(count_ff) - 1'b1)
   `RTA_ASSERT_NEXT(a_front_push_fills, clock, reset, push && !q_pop, count_ff == $past(count_ff) + 1'b1)

endmodule

@@ hdl/rta_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_back
// Executes queued requests against the ID tables and holds the response.
// ----------------------------------------------------------------------------
`include "request_id_allocator_with_credits_defines.svh"

module rta_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   input  rta_pkg::cmd_type                      q_data,
   output logic                                  q_pop,
   input  logic                                  csr_write,
   input  logic [rta_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [rta_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic [rta_pkg::CODE_BITS-1:0]         pending_code,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rta_pkg::MSG_ID_BITS-1:0]       rsp_result_id,
   output logic [rta_pkg::ERR_BITS-1:0]          rsp_error,
   output logic [rta_pkg::CREDIT_BITS-1:0]       rsp_credits_left
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   // Tables: flag vectors cleared by reset, status values in a memory
   logic [rta_pkg::ID_COUNT-1:0]        out_present_ff;
   logic [rta_pkg::ID_COUNT-1:0]        out_has_ff;
   logic [rta_pkg::ID_COUNT-1:0]        in_present_ff;
   logic [rta_pkg::STATUS_BITS-1:0]     out_status_mem [rta_pkg::ID_COUNT];

   logic [2:0]                          state_ff, state_in;
   rta_pkg::cmd_type                    cmd_ff, cmd_in;
   logic [rta_pkg::ID_BITS-1:0]         next_id_ff, next_id_in;
   logic [rta_pkg::CREDIT_BITS-1:0]     fc_ff, fc_in;
   logic [rta_pkg::ID_BITS-1:0]         issue_ff, issue_in;
   logic [rta_pkg::ID_BITS-1:0]         count_ff, count_in;
   logic [rta_pkg::MSG_ID_BITS-1:0]     res_id_ff, res_id_in;
   logic [rta_pkg::ERR_BITS-1:0]        res_err_ff, res_err_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rta_pkg::MSG_ID_BITS-1:0]     rsp_id_ff;
   logic [rta_pkg::ERR_BITS-1:0]        rsp_err_ff;
   logic [rta_pkg::CREDIT_BITS-1:0]     rsp_cred_ff;

   // Registered table read
   logic [rta_pkg::ID_BITS-1:0]         rd_addr;
   logic [rta_pkg::ID_BITS-1:0]         eval_ff;
   logic                                pres_rd_ff;
   logic                                has_rd_ff;
   logic                                in_rd_ff;
   logic [rta_pkg::STATUS_BITS-1:0]     stat_rd_ff;

   logic [rta_pkg::STATUS_BITS-1:0]     pend;
   logic                                hit;
   logic                                alloc;
   logic                                reply_wr;
   logic                                req_wr;
   logic                                rsp_load;

   assign pend    = rta_pkg::STATUS_BITS'(pending_code);
   assign rd_addr = (cmd_ff.op == rta_pkg::OP_SEND) ? issue_ff : cmd_ff.id;

   // Probe is reusable when free or holding a final status
   assign hit = !pres_rd_ff || (has_rd_ff && (stat_rd_ff != pend));

   // Sequence one request at a time
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      next_id_in = next_id_ff;
      fc_in      = fc_ff;
      issue_in   = issue_ff;
      count_in   = count_ff;
      res_id_in  = res_id_ff;
      res_err_in = res_err_ff;
      alloc      = 1'b0;
      reply_wr   = 1'b0;
      req_wr     = 1'b0;
      q_pop      = 1'b0;
      rsp_load   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               issue_in = next_id_ff;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (cmd_ff.op == rta_pkg::OP_SEND) begin
               if (fc_ff == '0) begin
                  res_id_in  = rta_pkg::MSG_ID_BITS'(next_id_ff);
                  res_err_in = rta_pkg::ERR_NO_CREDIT;
                  state_in   = S_DONE;
               end else begin
                  issue_in = rta_pkg::wrap_next(issue_ff);
                  count_in = '0;
                  state_in = S_SCAN;
               end
            end else begin
               state_in = S_EXEC;
            end
         end
         S_SCAN: begin
            // evaluate one probe per cycle while the next read is in flight
            if (hit) begin
               alloc      = 1'b1;
               fc_in      = fc_ff - 1'b1;
               next_id_in = rta_pkg::wrap_next(eval_ff);
               res_id_in  = rta_pkg::MSG_ID_BITS'(eval_ff);
               res_err_in = rta_pkg::ERR_OK;
               state_in   = S_DONE;
            end else if (count_ff == rta_pkg::ID_BITS'(rta_pkg::ID_COUNT - 1)) begin
               res_id_in  = rta_pkg::MSG_ID_BITS'(next_id_ff);
               res_err_in = rta_pkg::ERR_NO_ID;
               state_in   = S_DONE;
            end else begin
               count_in = count_ff + 1'b1;
               issue_in = rta_pkg::wrap_next(issue_ff);
            end
         end
         S_EXEC: begin
            res_id_in  = cmd_ff.msg_id;
            res_err_in = rta_pkg::ERR_OK;
            state_in   = S_DONE;
            unique case (cmd_ff.op)
               rta_pkg::OP_RX_REPLY: begin
                  if (!cmd_ff.id_ok || !pres_rd_ff) begin
                     res_err_in = rta_pkg::ERR_UNKNOWN;
                  end else if (!(has_rd_ff && (stat_rd_ff == cmd_ff.code))) begin
                     reply_wr = 1'b1;
                     // return a credit when a final status first lands
                     if ((!has_rd_ff || (stat_rd_ff == pend)) && (cmd_ff.code != pend) &&
                         (fc_ff != rta_pkg::CREDIT_MAX)) begin
                        fc_in = fc_ff + 1'b1;
                     end
                  end
               end
               rta_pkg::OP_RX_REQ: begin
                  if (!cmd_ff.id_ok) begin
                     res_err_in = rta_pkg::ERR_UNKNOWN;
                  end else begin
                     req_wr = 1'b1;
                  end
               end
               rta_pkg::OP_TX_REPLY: begin
                  if (!cmd_ff.id_ok || !in_rd_ff) begin
                     res_err_in = rta_pkg::ERR_UNKNOWN;
                  end
               end
               rta_pkg::OP_SEND: begin
                  // sends never reach this state
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a slot limit write reloads the credit counter
      if (csr_write && (csr_index == rta_pkg::CSR_SLOT_LIMIT)) begin
         fc_in = csr_wdata;
      end
   end

   // Hold the response until taken
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_id_ff   <= '0;
         fc_ff        <= rta_pkg::SLOT_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_id_ff   <= next_id_in;
         fc_ff        <= fc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      issue_ff   <= issue_in;
      count_ff   <= count_in;
      res_id_ff  <= res_id_in;
      res_err_ff <= res_err_in;
      if (rsp_load) begin
         rsp_id_ff   <= res_id_ff;
         rsp_err_ff  <= res_err_ff;
         rsp_cred_ff <= fc_ff;
      end
   end

   // Update entry flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_present_ff <= '0;
         out_has_ff     <= '0;
         in_present_ff  <= '0;
      end else begin
         if (alloc) begin
            out_present_ff[eval_ff] <= 1'b1;
            out_has_ff[eval_ff]     <= 1'b0;
         end
         if (reply_wr) begin
            out_has_ff[cmd_ff.id] <= 1'b1;
         end
         if (req_wr) begin
            in_present_ff[cmd_ff.id] <= 1'b1;
         end
      end
   end

   // Status memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (reply_wr) begin
         out_status_mem[cmd_ff.id] <= cmd_ff.code;
      end
      stat_rd_ff <= out_status_mem[rd_addr];
   end

   // Register flag reads alongside the status read
   always_ff @(posedge clock) begin
      eval_ff    <= rd_addr;
      pres_rd_ff <= out_present_ff[rd_addr];
      has_rd_ff  <= out_has_ff[rd_addr];
      in_rd_ff   <= in_present_ff[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_error        = rsp_err_ff;
   assign rsp_credits_left = rsp_cred_ff;

   `RTA_ASSERT(a_back_alloc_has_credit, clock, reset, !alloc || (fc_ff != '0))
   `RTA_ASSERT_NEXT(a_back_done_exit, clock, reset, state_ff == S_DONE, (state_ff == S_DONE) || (state_ff == S_IDLE))
   `RTA_ASSERT(a_back_rsp_from_done, clock, reset, !$rose(rsp_valid_ff) || ($past(state_ff) == S_DONE))

endmodule

@@ hdl/request_id_allocator_with_credits.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_id_allocator_with_credits
// Outstanding request ID allocator with send credits for one side of a link.
// A send request takes one credit and allocates an ID by scanning the table
// forward from the last allocation, one ID per cycle through a registered
// table read; replies record status and return credits, incoming requests
// and our replies track the incoming IDs. A small queue parts request intake
// from execution, and a response register parts execution from the consumer.
// A send that finds no reusable ID reports error 3; the scan over the
// table sets the send time. Writing the slot limit reloads the free credit
// count. Registers must be written by the user only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------

module request_id_allocator_with_credits (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [rta_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [rta_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [rta_pkg::MODE_BITS-1:0]         req_mode,
   input  logic [rta_pkg::MSG_ID_BITS-1:0]       req_message_id,
   input  logic [rta_pkg::CODE_BITS-1:0]         req_status_code,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rta_pkg::MSG_ID_BITS-1:0]       rsp_result_id,
   output logic [rta_pkg::ERR_BITS-1:0]          rsp_error,
   output logic [rta_pkg::CREDIT_BITS-1:0]       rsp_credits_left
);

   logic [rta_pkg::CODE_BITS-1:0] pending_code_ff;
   logic                          q_valid;
   logic                          q_pop;
   rta_pkg::cmd_type              q_data;

   // Hold the pending status code
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_code_ff <= '0;
      end else if (csr_write && (csr_index == rta_pkg::CSR_PENDING_CODE)) begin
         pending_code_ff <= csr_wdata;
      end
   end

   // Accept and queue requests
   rta_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_message_id  (req_message_id),
      .req_status_code (req_status_code),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .q_pop           (q_pop)
   );

   // Execute against the ID tables
   rta_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .pending_code     (pending_code_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_id    (rsp_result_id),
      .rsp_error        (rsp_error),
      .rsp_credits_left (rsp_credits_left)
   );

endmodule

@@ tb/id_alloc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_alloc_checker
// Watches the request, response and register ports of the ID allocator. It
// keeps its own copy of the ID tables, credit count and registers, works out
// the response of every accepted request, and compares each accepted response
// with the oldest one still due.
// ----------------------------------------------------------------------------

module id_alloc_checker
   import rta_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [MODE_BITS-1:0]     req_mode,
   input  logic [MSG_ID_BITS-1:0]   req_message_id,
   input  logic [CODE_BITS-1:0]     req_status_code,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [MSG_ID_BITS-1:0]   rsp_result_id,
   input  logic [ERR_BITS-1:0]      rsp_error,
   input  logic [CREDIT_BITS-1:0]   rsp_credits_left,
   output int                       mismatch_count,
   output int                       outcomes_due
);

   typedef struct packed {
      logic [MSG_ID_BITS-1:0] id;
      logic [ERR_BITS-1:0]    err;
      logic [CREDIT_BITS-1:0] credits;
   } outcome_t;

   // Mirror of the outgoing and incoming ID tables
   bit                       out_present    [ID_COUNT];
   bit                       out_has_status [ID_COUNT];
   logic [STATUS_BITS-1:0]   out_status     [ID_COUNT];
   bit                       in_present     [ID_COUNT];
   bit                       in_has_status  [ID_COUNT];
   logic [STATUS_BITS-1:0]   in_status      [ID_COUNT];
   logic [ID_BITS-1:0]       next_id;
   logic [CREDIT_BITS-1:0]   free_credits;
   logic [CSR_DATA_BITS-1:0] pending_code;

   // Responses still owed by the block, oldest first
   outcome_t expected_outcomes[$];

   // Print one line per mismatch (bounded) and count it
   task automatic report_mismatch(input string msg);
      if (mismatch_count < 200) begin
         $display("%0t id_alloc_checker: mismatch: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   // Apply one request to the mirror and return the response it must produce
   function automatic outcome_t apply_request(input logic [MODE_BITS-1:0]   mode,
                                              input logic [MSG_ID_BITS-1:0] msg_id,
                                              input logic [CODE_BITS-1:0]   code_in);
      outcome_t               o;
      logic [ID_BITS-1:0]     idx;
      logic [ID_BITS-1:0]     probe;
      logic [STATUS_BITS-1:0] code;
      logic [STATUS_BITS-1:0] pend;
      bit                     known;
      bit                     found;
      bit                     had;
      idx   = msg_id[ID_BITS-1:0];
      code  = code_in[STATUS_BITS-1:0];
      pend  = pending_code[STATUS_BITS-1:0];
      known = int'(msg_id) < ID_COUNT;
      o.id  = msg_id;
      o.err = ERR_OK;
      case (mode)
         OP_SEND: begin
            o.id = MSG_ID_BITS'(next_id);
            if (free_credits == '0) begin
               o.err = ERR_NO_CREDIT;
            end else begin
               // Scan forward for a free entry or one holding a final status
               probe = next_id;
               found = 1'b0;
               for (int i = 0; i < ID_COUNT && !found; i++) begin
                  if (!out_present[probe] ||
                      (out_has_status[probe] && out_status[probe] != pend)) begin
                     found = 1'b1;
                  end else begin
                     probe = (probe == ID_BITS'(ID_COUNT - 1)) ? '0 : probe + 1'b1;
                  end
               end
               if (!found) begin
                  o.err = ERR_NO_ID;
               end else begin
                  free_credits--;
                  out_present[probe]    = 1'b1;
                  out_has_status[probe] = 1'b0;
                  o.id    = MSG_ID_BITS'(probe);
                  next_id = (probe == ID_BITS'(ID_COUNT - 1)) ? '0 : probe + 1'b1;
               end
            end
         end
         OP_RX_REPLY: begin
            if (!known || !out_present[idx]) begin
               o.err = ERR_UNKNOWN;
            end else begin
               had = out_has_status[idx];
               // Ignore a repeat of the stored status
               if (!(had && out_status[idx] == code)) begin
                  if ((!had || out_status[idx] == pend) && code != pend &&
                      free_credits != CREDIT_MAX) begin
                     free_credits++;
                  end
                  out_status[idx]     = code;
                  out_has_status[idx] = 1'b1;
               end
            end
         end
         OP_RX_REQ: begin
            if (!known) begin
               o.err = ERR_UNKNOWN;
            end else begin
               in_present[idx]    = 1'b1;
               in_has_status[idx] = 1'b0;
            end
         end
         default: begin
            if (!known || !in_present[idx]) begin
               o.err = ERR_UNKNOWN;
            end else begin
               in_status[idx]     = code;
               in_has_status[idx] = 1'b1;
            end
         end
      endcase
      o.credits = free_credits;
      return o;
   endfunction

   // Track registers, predict each request, check each response
   always @(posedge clock) begin
      outcome_t want;
      if (reset) begin
         foreach (out_present[i]) begin
            out_present[i]    = 1'b0;
            out_has_status[i] = 1'b0;
            out_status[i]     = '0;
            in_present[i]     = 1'b0;
            in_has_status[i]  = 1'b0;
            in_status[i]      = '0;
         end
         next_id        = '0;
         free_credits   = SLOT_LIMIT_RESET;
         pending_code   = '0;
         mismatch_count = 0;
         expected_outcomes.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_SLOT_LIMIT) begin
               free_credits = csr_wdata[CREDIT_BITS-1:0];
            end else if (csr_index == CSR_PENDING_CODE) begin
               pending_code = csr_wdata;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch($sformatf("response id %0d err %0d with no request due",
                                         rsp_result_id, rsp_error));
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_result_id !== want.id) begin
                  report_mismatch($sformatf("result_id %0d, expected %0d",
                                            rsp_result_id, want.id));
               end
               if (rsp_error !== want.err) begin
                  report_mismatch($sformatf("error %0d, expected %0d",
                                            rsp_error, want.err));
               end
               if (rsp_credits_left !== want.credits) begin
                  report_mismatch($sformatf("credits_left %0d, expected %0d",
                                            rsp_credits_left, want.credits));
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_outcomes.push_back(apply_request(req_mode, req_message_id,
                                                      req_status_code));
         end
      end
      outcomes_due <= expected_outcomes.size();
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the request ID allocator with a directed opening, random phases
// under several register settings, and a closing phase that fills the whole
// ID table until a scan finds nothing. Both channel sides idle at random.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------

module tb_top;
   import rta_pkg::*;

   logic                     clock;
   logic                     reset;
   logic                     csr_write;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   logic                     req_valid;
   logic                     req_stall;
   logic [MODE_BITS-1:0]     req_mode;
   logic [MSG_ID_BITS-1:0]   req_message_id;
   logic [CODE_BITS-1:0]     req_status_code;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [MSG_ID_BITS-1:0]   rsp_result_id;
   logic [ERR_BITS-1:0]      rsp_error;
   logic [CREDIT_BITS-1:0]   rsp_credits_left;

   int                       mismatch_count;
   int                       outcomes_due;
   bit                       source_lazy;
   bit                       sink_lazy;
   int unsigned              sink_hold;
   int unsigned              sink_draw;
   logic [CSR_DATA_BITS-1:0] pend_now;
   logic [ERR_BITS-1:0]      last_err;

   // Modes in flight, IDs handed out by the block, incoming IDs recorded
   logic [MODE_BITS-1:0]     sent_modes[$];
   logic [MSG_ID_BITS-1:0]   live_ids[$];
   logic [MSG_ID_BITS-1:0]   fresh_ids[$];
   logic [MSG_ID_BITS-1:0]   in_ids[$];

   request_id_allocator_with_credits DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_message_id   (req_message_id),
      .req_status_code  (req_status_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_id    (rsp_result_id),
      .rsp_error        (rsp_error),
      .rsp_credits_left (rsp_credits_left)
   );

   id_alloc_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_message_id   (req_message_id),
      .req_status_code  (req_status_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_id    (rsp_result_id),
      .rsp_error        (rsp_error),
      .rsp_credits_left (rsp_credits_left),
      .mismatch_count   (mismatch_count),
      .outcomes_due     (outcomes_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Bail out if the block hangs
   initial begin
      #20000000;
      $display("tb_top: errors");
      $finish;
   end

   // Hold off a random number of cycles after each accepted response
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_hold <= 0;
      end else if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
         rsp_stall <= (sink_hold > 1);
      end else if (rsp_valid && !rsp_stall) begin
         sink_draw = sink_lazy ? $urandom_range(0, 11) : 0;
         sink_hold <= sink_draw;
         rsp_stall <= (sink_draw != 0);
      end
   end

   // Note the outcome of each response; keep IDs that sends handed out
   always @(posedge clock) begin
      logic [MODE_BITS-1:0] m;
      if (!reset && rsp_valid && !rsp_stall && sent_modes.size() != 0) begin
         m = sent_modes.pop_front();
         last_err <= rsp_error;
         if (m == OP_SEND && rsp_error == ERR_OK) begin
            live_ids.push_back(rsp_result_id);
            if (live_ids.size() > 48) begin
               void'(live_ids.pop_front());
            end
            fresh_ids.push_back(rsp_result_id);
         end
      end
   end

   // Present one request after a random gap and hold it until accepted
   task automatic put_request(input logic [MODE_BITS-1:0]   mode,
                              input logic [MSG_ID_BITS-1:0] id,
                              input logic [CODE_BITS-1:0]   code);
      int unsigned gap;
      gap = source_lazy ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_message_id  <= id;
      req_status_code <= code;
      do @(posedge clock); while (req_stall);
      sent_modes.push_back(mode);
   endtask

   // Stop sending and wait until every response has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outcomes_due != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0]  idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Drain, then load both registers
   task automatic configure(input logic [CSR_DATA_BITS-1:0] slots,
                            input logic [CSR_DATA_BITS-1:0] pend);
      settle();
      write_reg(CSR_SLOT_LIMIT, slots);
      write_reg(CSR_PENDING_CODE, pend);
      csr_write <= 1'b0;
      pend_now = pend;
   endtask

   // Favor the pending code and a few small codes so repeats and
   // pending-to-final transitions happen often
   function automatic logic [CODE_BITS-1:0] pick_status();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 3) begin
         return pend_now;
      end else if (r < 6) begin
         return CODE_BITS'($urandom_range(1, 3));
      end
      return CODE_BITS'($urandom);
   endfunction

   initial begin
      logic [CSR_DATA_BITS-1:0] slots;
      logic [CSR_DATA_BITS-1:0] pend;
      logic [MSG_ID_BITS-1:0]   id;
      int unsigned              r;
      int unsigned              k;
      bit                       table_full;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= OP_SEND;
      req_message_id  <= '0;
      req_status_code <= '0;
      csr_write       <= 1'b0;
      csr_index       <= CSR_SLOT_LIMIT;
      csr_wdata       <= '0;
      source_lazy = 1'b1;
      sink_lazy   = 1'b1;
      pend_now    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: unknown IDs, first sends, status repeats and transitions
      put_request(OP_RX_REPLY, 8'h00, 8'h09);
      put_request(OP_TX_REPLY, 8'hFF, 8'h00);
      put_request(OP_SEND,     8'hFF, 8'hFF);
      put_request(OP_SEND,     8'h00, 8'h00);
      put_request(OP_RX_REPLY, 8'h00, 8'h00);
      put_request(OP_RX_REPLY, 8'h00, 8'h00);
      put_request(OP_RX_REPLY, 8'h00, 8'hFF);
      put_request(OP_RX_REPLY, 8'h00, 8'hFF);
      put_request(OP_RX_REPLY, 8'h00, 8'h00);
      put_request(OP_RX_REPLY, 8'h01, 8'hAA);
      put_request(OP_SEND,     8'h55, 8'hAA);
      // Incoming requests, our replies, and overwrite of a present entry
      put_request(OP_RX_REQ,   8'hFF, 8'h00);
      put_request(OP_TX_REPLY, 8'hFF, 8'hFF);
      put_request(OP_RX_REQ,   8'hFF, 8'hFF);
      put_request(OP_TX_REPLY, 8'hFF, 8'h00);
      put_request(OP_RX_REQ,   8'h00, 8'hFF);
      put_request(OP_TX_REPLY, 8'h00, 8'h55);
      // No credit left, then one credit back
      configure(8'h00, 8'h00);
      put_request(OP_SEND,     8'h12, 8'h34);
      put_request(OP_RX_REPLY, 8'h02, 8'h03);
      put_request(OP_SEND,     8'h00, 8'h00);
      // Credit count saturates at the top
      configure(8'hFF, 8'hFF);
      put_request(OP_RX_REPLY, 8'h03, 8'h10);
      put_request(OP_SEND,     8'h00, 8'h00);

      // Random phases under several register settings
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin slots = 8'd16;  pend = 8'h00; end
            1: begin slots = 8'hFF;  pend = 8'hFF; end
            2: begin slots = 8'd1;   pend = 8'h80; end
            3: begin slots = 8'd4;   pend = 8'($urandom); end
            4: begin slots = 8'($urandom); pend = 8'($urandom); end
            default: begin slots = 8'd2; pend = 8'h00; end
         endcase
         source_lazy = (p != 2) && (p != 5);
         sink_lazy   = (p != 4) && (p != 5);
         configure(slots, pend);
         repeat (150) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               put_request(MODE_BITS'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            end else if (r < 40) begin
               put_request(OP_SEND, 8'($urandom), 8'($urandom));
            end else if (r < 70) begin
               // Mostly reply to an ID the block handed out
               if (live_ids.size() != 0 && $urandom_range(0, 9) != 0) begin
                  k  = $urandom_range(0, live_ids.size() - 1);
                  id = live_ids[k];
                  if ($urandom_range(0, 1) != 0) begin
                     live_ids.delete(k);
                  end
               end else begin
                  id = 8'($urandom);
               end
               put_request(OP_RX_REPLY, id, pick_status());
            end else if (r < 85) begin
               id = 8'($urandom);
               in_ids.push_back(id);
               if (in_ids.size() > 32) begin
                  void'(in_ids.pop_front());
               end
               put_request(OP_RX_REQ, id, 8'($urandom));
            end else begin
               if (in_ids.size() != 0 && $urandom_range(0, 99) < 85) begin
                  id = in_ids[$urandom_range(0, in_ids.size() - 1)];
               end else begin
                  id = 8'($urandom);
               end
               put_request(OP_TX_REPLY, id, 8'($urandom));
            end
            // Now and then let everything drain mid-phase
            if ($urandom_range(0, 79) == 0) begin
               settle();
            end
         end
      end

      // Fill the table: allocate, and buy credits back by finalizing an ID
      // and then setting it pending again, until a scan finds nothing
      source_lazy = 1'b1;
      sink_lazy   = 1'b1;
      configure(8'hFF, 8'h42);
      fresh_ids.delete();
      table_full = 1'b0;
      for (int n = 0; n < 400 && !table_full; n++) begin
         put_request(OP_SEND, 8'($urandom), 8'($urandom));
         settle();
         if (last_err == ERR_NO_ID) begin
            table_full = 1'b1;
         end else if (last_err == ERR_NO_CREDIT && fresh_ids.size() != 0) begin
            id = fresh_ids.pop_front();
            put_request(OP_RX_REPLY, id, 8'h43);
            put_request(OP_RX_REPLY, id, 8'h42);
            settle();
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
